// ----- hw/rtl/dlc_pkg.sv -----
// ----------------------------------------------------------------------------
// dlc_pkg
// Shared types and constants of the password door lock controller: message
// codes, motor levels, register map and the structs passed between modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dlc_pkg;

    // Message codes carried on each result.
    localparam logic [3:0] MSG_SAVED     = 4'd0;
    localparam logic [3:0] MSG_NONE      = 4'd1;
    localparam logic [3:0] MSG_NEWOK     = 4'd2;
    localparam logic [3:0] MSG_NEWBAD    = 4'd3;
    localparam logic [3:0] MSG_OK        = 4'd4;
    localparam logic [3:0] MSG_WRONG     = 4'd5;
    localparam logic [3:0] MSG_THIEF     = 4'd6;
    localparam logic [3:0] MSG_UNLOCKING = 4'd7;
    localparam logic [3:0] MSG_LOCKING   = 4'd8;
    localparam logic [3:0] MSG_LOCKED    = 4'd9;
    localparam logic [3:0] MSG_UNLOCKED  = 4'd10;

    // Motor drive levels.
    localparam logic [1:0] MOTOR_STOP = 2'd0;
    localparam logic [1:0] MOTOR_CW   = 2'd1;
    localparam logic [1:0] MOTOR_CCW  = 2'd2;

    // Input opcodes.
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Configuration register map (index = paddr[4:2]).
    localparam int unsigned ADDR_W = 5;
    localparam logic [2:0] REG_CHECK_CMD    = 3'd0;
    localparam logic [2:0] REG_READY_CMD    = 3'd1;
    localparam logic [2:0] REG_OPEN_KEY     = 3'd2;
    localparam logic [2:0] REG_CHANGE_KEY   = 3'd3;
    localparam logic [2:0] REG_MAX_FAILURES = 3'd4;
    localparam logic [2:0] REG_UNLOCK_TICKS = 3'd5;
    localparam logic [2:0] REG_RELOCK_TICKS = 3'd6;
    localparam logic [2:0] REG_ALARM_TICKS  = 3'd7;

    // Register reset values.
    localparam logic [7:0] RST_CHECK_CMD    = 8'd1;
    localparam logic [7:0] RST_READY_CMD    = 8'd2;
    localparam logic [7:0] RST_OPEN_KEY     = 8'd3;
    localparam logic [7:0] RST_CHANGE_KEY   = 8'd4;
    localparam logic [3:0] RST_MAX_FAILURES = 4'd3;
    localparam logic [7:0] RST_UNLOCK_TICKS = 8'd3;
    localparam logic [7:0] RST_RELOCK_TICKS = 8'd6;
    localparam logic [7:0] RST_ALARM_TICKS  = 8'd12;

    localparam logic [3:0] FAIL_SAT = 4'd15;

    // Result queue sizing: one item can produce two results.
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [7:0] check_command;
        logic [7:0] ready_command;
        logic [7:0] open_key;
        logic [7:0] change_key;
        logic [3:0] max_failures;
        logic [7:0] unlock_ticks;
        logic [7:0] relock_ticks;
        logic [7:0] alarm_ticks;
    } t_cfg;

    typedef struct packed {
        logic [3:0] msg_code;
        logic [1:0] motor_drive;
        logic       buzzer_on;
        logic       last;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_step;

    typedef struct packed {
        logic [Q_CNT_W-1:0] count;
    } t_q_status;

endpackage

`default_nettype wire

// ----- hw/rtl/password_door_lock_controller_core.sv -----
// The results of an item are written into the result queue at its transfer.
// Throughput: one item per cycle while results drain; output is one result per
// cycle unless stalled, so items that cause two results run at the output rate.
// Input stalls whenever the four-entry result queue holds more than two results.
// Synchronous active-low reset: idle mode, no password saved, motor stopped.
// ----------------------------------------------------------------------------
// password_door_lock_controller_core
// Top level: configuration registers, protocol state machine and result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module password_door_lock_controller_core #(
    parameter int unsigned PASS_LEN = 5
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic                       i_opcode,
    input  wire logic [7:0]                 i_rx_byte,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic      [3:0]                 o_msg_code,
    output logic      [1:0]                 o_motor_drive,
    output logic                            o_buzzer_on,
    output logic                            o_last,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [dlc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready
);
    import dlc_pkg::*;

    t_cfg      cfg;
    t_step     step;
    t_result   result;
    t_q_status q_status;
    logic      accept;

    // Room for the worst case of two results from the next item.
    assign o_in_stall = (q_status.count > Q_CNT_W'(Q_DEPTH - 2));
    assign accept     = i_in_valid & ~o_in_stall;

    dlc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    dlc_fsm #(
        .PASS_LEN (PASS_LEN)
    ) u_fsm (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_opcode  (i_opcode),
        .i_rx_byte (i_rx_byte),
        .i_cfg     (cfg),
        .o_step    (step)
    );

    dlc_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (accept),
        .i_step      (step),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (result),
        .o_status    (q_status)
    );

    assign o_msg_code    = result.msg_code;
    assign o_motor_drive = result.motor_drive;
    assign o_buzzer_on   = result.buzzer_on;
    assign o_last        = result.last;

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.count <= Q_CNT_W'(Q_DEPTH))
        else $error("result queue count exceeds its depth");

    a_accept_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (q_status.count != '0) || ($past(step.count) == 2'd0))
        else $error("results of an accepted item were not queued");

    a_unlock_motor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_msg_code == MSG_UNLOCKING) |-> (o_motor_drive == MOTOR_CW))
        else $error("unlocking message without clockwise motor");

    a_thief_buzzer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_msg_code == MSG_THIEF) |-> o_buzzer_on)
        else $error("lockout message without buzzer");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/dlc_regs.sv -----
// ----------------------------------------------------------------------------
// dlc_regs
// APB-style configuration registers of the door lock controller.
// ----------------------------------------------------------------------------
`default_nettype none

module dlc_regs (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [dlc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready,
    output dlc_pkg::t_cfg                   o_cfg
);
    import dlc_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.check_command <= RST_CHECK_CMD;
            r_cfg.ready_command <= RST_READY_CMD;
            r_cfg.open_key      <= RST_OPEN_KEY;
            r_cfg.change_key    <= RST_CHANGE_KEY;
            r_cfg.max_failures  <= RST_MAX_FAILURES;
            r_cfg.unlock_ticks  <= RST_UNLOCK_TICKS;
            r_cfg.relock_ticks  <= RST_RELOCK_TICKS;
            r_cfg.alarm_ticks   <= RST_ALARM_TICKS;
        end else if (wr_en) begin
            case (reg_idx)
                REG_CHECK_CMD:    r_cfg.check_command <= pwdata[7:0];
                REG_READY_CMD:    r_cfg.ready_command <= pwdata[7:0];
                REG_OPEN_KEY:     r_cfg.open_key      <= pwdata[7:0];
                REG_CHANGE_KEY:   r_cfg.change_key    <= pwdata[7:0];
                REG_MAX_FAILURES: r_cfg.max_failures  <= pwdata[3:0];
                REG_UNLOCK_TICKS: r_cfg.unlock_ticks  <= pwdata[7:0];
                REG_RELOCK_TICKS: r_cfg.relock_ticks  <= pwdata[7:0];
                REG_ALARM_TICKS:  r_cfg.alarm_ticks   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_CHECK_CMD:    prdata = {24'd0, r_cfg.check_command};
            REG_READY_CMD:    prdata = {24'd0, r_cfg.ready_command};
            REG_OPEN_KEY:     prdata = {24'd0, r_cfg.open_key};
            REG_CHANGE_KEY:   prdata = {24'd0, r_cfg.change_key};
            REG_MAX_FAILURES: prdata = {28'd0, r_cfg.max_failures};
            REG_UNLOCK_TICKS: prdata = {24'd0, r_cfg.unlock_ticks};
            REG_RELOCK_TICKS: prdata = {24'd0, r_cfg.relock_ticks};
            REG_ALARM_TICKS:  prdata = {24'd0, r_cfg.alarm_ticks};
            default:          prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- hw/rtl/dlc_fsm.sv -----
// ----------------------------------------------------------------------------
// dlc_fsm
// Protocol state machine: handles one link byte or timer tick per transfer,
// updates the lock state and produces up to two results for that item.
// ----------------------------------------------------------------------------
`default_nettype none

module dlc_fsm #(
    parameter int unsigned PASS_LEN = 5
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire logic          i_opcode,
    input  wire logic [7:0]    i_rx_byte,
    input  wire dlc_pkg::t_cfg i_cfg,
    output dlc_pkg::t_step     o_step
);
    import dlc_pkg::*;

    localparam int unsigned IDX_W = (PASS_LEN > 1) ? $clog2(PASS_LEN) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PASS_LEN - 1);

    typedef enum logic [2:0] {
        M_WAIT_CHECK,
        M_NEW_READY,
        M_NEW_BYTES,
        M_CONF_READY,
        M_CONF_BYTES,
        M_VER_READY,
        M_VER_BYTES,
        M_VER_KEY
    } t_mode;

    t_mode            r_mode,      n_mode;
    logic [IDX_W-1:0] r_idx,       n_idx;
    logic             r_mismatch,  n_mismatch;
    logic [7:0]       r_cand   [PASS_LEN];
    logic [7:0]       r_stored [PASS_LEN];
    logic             r_valid,     n_valid;
    logic [3:0]       r_failures,  n_failures;
    logic             r_fail,      n_fail;
    logic             r_timer,     n_timer;
    logic [7:0]       r_ticks,     n_ticks;
    logic [1:0]       r_motor,     n_motor;
    logic             r_buzzer,    n_buzzer;
    t_step            n_step;
    logic             cand_we;
    logic             commit;

    function automatic t_result mk_res(input logic [3:0] msg, input logic [1:0] motor,
                                       input logic buzzer);
        t_result r;
        r.msg_code    = msg;
        r.motor_drive = motor;
        r.buzzer_on   = buzzer;
        r.last        = 1'b0;
        return r;
    endfunction

    always_comb begin
        t_result res;
        n_mode     = r_mode;
        n_idx      = r_idx;
        n_mismatch = r_mismatch;
        n_valid    = r_valid;
        n_failures = r_failures;
        n_fail     = r_fail;
        n_timer    = r_timer;
        n_ticks    = r_ticks;
        n_motor    = r_motor;
        n_buzzer   = r_buzzer;
        cand_we    = 1'b0;
        commit     = 1'b0;
        n_step     = '0;
        res        = '0;

        if (i_opcode == OP_TICK) begin
            if (r_timer) begin
                n_ticks = r_ticks + 8'd1;
                if (n_ticks == i_cfg.unlock_ticks && !r_fail) begin
                    n_motor = MOTOR_CCW;
                    n_step.res0  = mk_res(MSG_LOCKING, n_motor, n_buzzer);
                    n_step.count = 2'd1;
                end
                if (n_ticks == i_cfg.relock_ticks && !r_fail) begin
                    n_motor = MOTOR_STOP;
                    res     = mk_res(MSG_LOCKED, n_motor, n_buzzer);
                    if (n_step.count == 2'd0) begin
                        n_step.res0 = res;
                    end else begin
                        n_step.res1 = res;
                    end
                    n_step.count = n_step.count + 2'd1;
                    n_ticks = 8'd0;
                    n_timer = 1'b0;
                    n_mode  = M_VER_READY;
                    n_idx   = '0;
                end
                // Alarm end only happens with the fail flag set, so it never
                // shares a tick with the close steps.
                if (n_ticks == i_cfg.alarm_ticks && r_fail) begin
                    n_buzzer     = 1'b0;
                    n_step.res0  = mk_res(MSG_UNLOCKED, n_motor, n_buzzer);
                    n_step.count = 2'd1;
                    n_ticks      = 8'd0;
                    n_timer      = 1'b0;
                    n_failures   = 4'd0;
                end
            end
        end else begin
            case (r_mode)
                M_WAIT_CHECK: begin
                    if (i_rx_byte == i_cfg.check_command) begin
                        n_step.count = 2'd1;
                        if (r_valid) begin
                            n_step.res0 = mk_res(MSG_SAVED, r_motor, r_buzzer);
                            n_mode      = M_VER_READY;
                        end else begin
                            n_step.res0 = mk_res(MSG_NONE, r_motor, r_buzzer);
                            n_mode      = M_NEW_READY;
                        end
                    end
                end
                M_NEW_READY, M_CONF_READY, M_VER_READY: begin
                    if (i_rx_byte == i_cfg.ready_command) begin
                        n_idx      = '0;
                        n_mismatch = 1'b0;
                        case (r_mode)
                            M_NEW_READY:  n_mode = M_NEW_BYTES;
                            M_CONF_READY: n_mode = M_CONF_BYTES;
                            default:      n_mode = M_VER_BYTES;
                        endcase
                    end
                end
                M_NEW_BYTES: begin
                    cand_we = 1'b1;
                    if (r_idx == IDX_LAST) begin
                        n_idx  = '0;
                        n_mode = M_CONF_READY;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
                M_CONF_BYTES: begin
                    n_mismatch = r_mismatch | (r_cand[r_idx] != i_rx_byte);
                    if (r_idx == IDX_LAST) begin
                        n_idx        = '0;
                        n_step.count = 2'd1;
                        if (!n_mismatch) begin
                            commit      = 1'b1;
                            n_valid     = 1'b1;
                            n_step.res0 = mk_res(MSG_NEWOK, r_motor, r_buzzer);
                            n_mode      = M_VER_READY;
                        end else begin
                            n_step.res0 = mk_res(MSG_NEWBAD, r_motor, r_buzzer);
                            n_mode      = M_NEW_READY;
                        end
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
                M_VER_BYTES: begin
                    n_mismatch = r_mismatch | (r_stored[r_idx] != i_rx_byte);
                    if (r_idx == IDX_LAST) begin
                        n_idx  = '0;
                        n_mode = M_VER_KEY;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
                M_VER_KEY: begin
                    n_mode = M_VER_READY;
                    n_idx  = '0;
                    if (!r_mismatch) begin
                        n_fail       = 1'b0;
                        n_failures   = 4'd0;
                        n_step.res0  = mk_res(MSG_OK, r_motor, r_buzzer);
                        n_step.count = 2'd1;
                        if (i_rx_byte == i_cfg.open_key) begin
                            n_motor      = MOTOR_CW;
                            n_step.res1  = mk_res(MSG_UNLOCKING, n_motor, r_buzzer);
                            n_step.count = 2'd2;
                            n_timer      = 1'b1;
                            n_ticks      = 8'd0;
                        end
                        if (i_rx_byte == i_cfg.change_key) begin
                            n_mode = M_NEW_READY;
                        end
                    end else begin
                        n_fail = 1'b1;
                        if (r_failures != FAIL_SAT) begin
                            n_failures = r_failures + 4'd1;
                        end
                        n_step.count = 2'd1;
                        if (n_failures == i_cfg.max_failures) begin
                            n_buzzer    = 1'b1;
                            n_step.res0 = mk_res(MSG_THIEF, r_motor, n_buzzer);
                            n_timer     = 1'b1;
                            n_ticks     = 8'd0;
                        end else begin
                            n_step.res0 = mk_res(MSG_WRONG, r_motor, r_buzzer);
                        end
                    end
                end
                default: ;
            endcase
        end

        if (n_step.count == 2'd2) begin
            n_step.res1.last = 1'b1;
        end else begin
            n_step.res0.last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= M_WAIT_CHECK;
            r_idx      <= '0;
            r_mismatch <= 1'b0;
            r_valid    <= 1'b0;
            r_failures <= 4'd0;
            r_fail     <= 1'b0;
            r_timer    <= 1'b0;
            r_ticks    <= 8'd0;
            r_motor    <= MOTOR_STOP;
            r_buzzer   <= 1'b0;
        end else if (i_accept) begin
            r_mode     <= n_mode;
            r_idx      <= n_idx;
            r_mismatch <= n_mismatch;
            r_valid    <= n_valid;
            r_failures <= n_failures;
            r_fail     <= n_fail;
            r_timer    <= n_timer;
            r_ticks    <= n_ticks;
            r_motor    <= n_motor;
            r_buzzer   <= n_buzzer;
        end
    end

    // Password stores are plain registers with no reset.
    always_ff @(posedge i_clk) begin
        if (i_accept && cand_we) begin
            r_cand[r_idx] <= i_rx_byte;
        end
        if (i_accept && commit) begin
            r_stored <= r_cand;
        end
    end

    assign o_step = n_step;

endmodule

`default_nettype wire

// ----- hw/rtl/dlc_outq.sv -----
// ----------------------------------------------------------------------------
// dlc_outq
// Result queue: takes up to two results per cycle, hands out one per
// transfer on the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module dlc_outq (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire dlc_pkg::t_step i_step,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output dlc_pkg::t_result    o_result,
    output dlc_pkg::t_q_status  o_status
);
    import dlc_pkg::*;

    t_result            r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0] r_count,  n_count;
    logic [1:0]         push_cnt;
    logic               pop;

    assign push_cnt = i_push ? i_step.count : 2'd0;
    assign pop      = o_out_valid & ~i_out_stall;

    always_comb begin
        n_wr_ptr = r_wr_ptr + Q_PTR_W'(push_cnt);
        n_rd_ptr = r_rd_ptr + Q_PTR_W'(pop);
        n_count  = r_count + Q_CNT_W'(push_cnt) - Q_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_step.res0;
        end
        if (push_cnt == 2'd2) begin
            r_mem[r_wr_ptr + Q_PTR_W'(1)] <= i_step.res1;
        end
    end

    assign o_out_valid     = (r_count != '0);
    assign o_result        = r_mem[r_rd_ptr];
    assign o_status.count  = r_count;

endmodule

`default_nettype wire

// ----- tb/dlc_result_check.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dlc_result_check
// Watches the item, result and register ports of the door lock controller,
// predicts the messages of every accepted item and compares each result
// transfer, field by field, with the oldest message still awaited.
// ----------------------------------------------------------------------------
module dlc_result_check #(
    parameter int unsigned PASS_LEN = 5
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    input  wire logic                       i_in_stall,
    input  wire logic                       i_opcode,
    input  wire logic [7:0]                 i_rx_byte,
    input  wire logic                       i_out_valid,
    input  wire logic                       i_out_stall,
    input  wire logic [3:0]                 i_msg_code,
    input  wire logic [1:0]                 i_motor_drive,
    input  wire logic                       i_buzzer_on,
    input  wire logic                       i_last,
    input  wire logic                       i_psel,
    input  wire logic                       i_penable,
    input  wire logic                       i_pwrite,
    input  wire logic                       i_pready,
    input  wire logic [dlc_pkg::ADDR_W-1:0] i_paddr,
    input  wire logic [31:0]                i_pwdata,
    output int                              o_fail_count,
    output int                              o_pending
);
    import dlc_pkg::*;

    typedef enum logic [2:0] {
        MODE_WAIT_CHECK,
        MODE_NEW_READY,
        MODE_NEW_BYTES,
        MODE_CONF_READY,
        MODE_CONF_BYTES,
        MODE_VER_READY,
        MODE_VER_BYTES,
        MODE_VER_KEY
    } t_mode;

    t_cfg        cfg;
    t_mode       mode;
    int unsigned byte_idx;
    logic        mismatch_seen;
    logic [7:0]  candidate [PASS_LEN];
    logic [7:0]  saved_code [PASS_LEN];
    logic        code_saved;
    logic [3:0]  failures;
    logic        fail_flag;
    logic        timer_on;
    logic [7:0]  tick_cnt;
    logic [1:0]  motor_lvl;
    logic        buzzer_lvl;

    t_result step_msgs[$];
    t_result awaited_msgs[$];
    int      mismatch_cnt = 0;
    int      result_cnt = 0;

    task automatic report_mismatch(input string what);
        $display("ERROR t=%0t result %0d: %s", $realtime, result_cnt, what);
        mismatch_cnt++;
    endtask

    task automatic compare_field(input string name, input int got, input int want);
        if (got != want) begin
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
        end
    endtask

    function automatic void note_msg(input logic [3:0] msg);
        t_result r;
        r.msg_code    = msg;
        r.motor_drive = motor_lvl;
        r.buzzer_on   = buzzer_lvl;
        r.last        = 1'b0;
        step_msgs.push_back(r);
    endfunction

    function automatic void start_timer();
        timer_on = 1'b1;
        tick_cnt = 8'd0;
    endfunction

    task automatic reset_model();
        cfg.check_command = RST_CHECK_CMD;
        cfg.ready_command = RST_READY_CMD;
        cfg.open_key      = RST_OPEN_KEY;
        cfg.change_key    = RST_CHANGE_KEY;
        cfg.max_failures  = RST_MAX_FAILURES;
        cfg.unlock_ticks  = RST_UNLOCK_TICKS;
        cfg.relock_ticks  = RST_RELOCK_TICKS;
        cfg.alarm_ticks   = RST_ALARM_TICKS;
        mode          = MODE_WAIT_CHECK;
        byte_idx      = 0;
        mismatch_seen = 1'b0;
        for (int k = 0; k < PASS_LEN; k++) begin
            candidate[k]  = 8'd0;
            saved_code[k] = 8'd0;
        end
        code_saved = 1'b0;
        failures   = 4'd0;
        fail_flag  = 1'b0;
        timer_on   = 1'b0;
        tick_cnt   = 8'd0;
        motor_lvl  = MOTOR_STOP;
        buzzer_lvl = 1'b0;
    endtask

    task automatic write_cfg(input logic [2:0] idx, input logic [31:0] val);
        case (idx)
            REG_CHECK_CMD:    cfg.check_command = val[7:0];
            REG_READY_CMD:    cfg.ready_command = val[7:0];
            REG_OPEN_KEY:     cfg.open_key      = val[7:0];
            REG_CHANGE_KEY:   cfg.change_key    = val[7:0];
            REG_MAX_FAILURES: cfg.max_failures  = val[3:0];
            REG_UNLOCK_TICKS: cfg.unlock_ticks  = val[7:0];
            REG_RELOCK_TICKS: cfg.relock_ticks  = val[7:0];
            default:          cfg.alarm_ticks   = val[7:0];
        endcase
    endtask

    // The close steps only run while no failure is pending, the alarm end only
    // while one is, so a sequence whose flag flipped keeps counting.
    task automatic predict_tick();
        if (timer_on) begin
            tick_cnt = tick_cnt + 8'd1;
            if (tick_cnt == cfg.unlock_ticks && !fail_flag) begin
                motor_lvl = MOTOR_CCW;
                note_msg(MSG_LOCKING);
            end
            if (tick_cnt == cfg.relock_ticks && !fail_flag) begin
                motor_lvl = MOTOR_STOP;
                note_msg(MSG_LOCKED);
                tick_cnt = 8'd0;
                timer_on = 1'b0;
                mode     = MODE_VER_READY;
                byte_idx = 0;
            end
            if (tick_cnt == cfg.alarm_ticks && fail_flag) begin
                buzzer_lvl = 1'b0;
                note_msg(MSG_UNLOCKED);
                tick_cnt = 8'd0;
                timer_on = 1'b0;
                failures = 4'd0;
            end
        end
    endtask

    task automatic predict_byte(input logic [7:0] b);
        int unsigned idx;
        idx = byte_idx;
        case (mode)
            MODE_WAIT_CHECK: begin
                if (b == cfg.check_command) begin
                    if (code_saved) begin
                        note_msg(MSG_SAVED);
                        mode = MODE_VER_READY;
                    end else begin
                        note_msg(MSG_NONE);
                        mode = MODE_NEW_READY;
                    end
                end
            end
            MODE_NEW_READY, MODE_CONF_READY, MODE_VER_READY: begin
                if (b == cfg.ready_command) begin
                    byte_idx      = 0;
                    mismatch_seen = 1'b0;
                    case (mode)
                        MODE_NEW_READY:  mode = MODE_NEW_BYTES;
                        MODE_CONF_READY: mode = MODE_CONF_BYTES;
                        default:         mode = MODE_VER_BYTES;
                    endcase
                end
            end
            MODE_NEW_BYTES: begin
                if (idx < PASS_LEN) candidate[idx] = b;
                byte_idx = idx + 1;
                if (byte_idx >= PASS_LEN) mode = MODE_CONF_READY;
            end
            MODE_CONF_BYTES: begin
                if (idx < PASS_LEN && candidate[idx] != b) mismatch_seen = 1'b1;
                byte_idx = idx + 1;
                if (byte_idx >= PASS_LEN) begin
                    if (!mismatch_seen) begin
                        for (int k = 0; k < PASS_LEN; k++) saved_code[k] = candidate[k];
                        code_saved = 1'b1;
                        note_msg(MSG_NEWOK);
                        mode = MODE_VER_READY;
                    end else begin
                        note_msg(MSG_NEWBAD);
                        mode = MODE_NEW_READY;
                    end
                end
            end
            MODE_VER_BYTES: begin
                if (idx < PASS_LEN && saved_code[idx] != b) mismatch_seen = 1'b1;
                byte_idx = idx + 1;
                if (byte_idx >= PASS_LEN) mode = MODE_VER_KEY;
            end
            default: begin
                // Option key: equal open and change keys apply both actions.
                mode = MODE_VER_READY;
                if (!mismatch_seen) begin
                    fail_flag = 1'b0;
                    failures  = 4'd0;
                    note_msg(MSG_OK);
                    if (b == cfg.open_key) begin
                        motor_lvl = MOTOR_CW;
                        note_msg(MSG_UNLOCKING);
                        start_timer();
                    end
                    if (b == cfg.change_key) mode = MODE_NEW_READY;
                end else begin
                    fail_flag = 1'b1;
                    if (failures < FAIL_SAT) failures = failures + 4'd1;
                    if (failures == cfg.max_failures) begin
                        buzzer_lvl = 1'b1;
                        note_msg(MSG_THIEF);
                        start_timer();
                    end else begin
                        note_msg(MSG_WRONG);
                    end
                end
                byte_idx = 0;
            end
        endcase
    endtask

    task automatic predict_item(input logic op, input logic [7:0] b);
        step_msgs.delete();
        if (op == OP_TICK) predict_tick();
        else predict_byte(b);
        if (step_msgs.size() > 0) step_msgs[step_msgs.size() - 1].last = 1'b1;
        foreach (step_msgs[k]) awaited_msgs.push_back(step_msgs[k]);
    endtask

    task automatic check_result();
        t_result want;
        result_cnt++;
        if (awaited_msgs.size() == 0) begin
            report_mismatch($sformatf("message %0d arrived with nothing awaited", i_msg_code));
        end else begin
            want = awaited_msgs.pop_front();
            compare_field("msg_code", i_msg_code, want.msg_code);
            compare_field("motor_drive", i_motor_drive, want.motor_drive);
            compare_field("buzzer_on", i_buzzer_on, want.buzzer_on);
            compare_field("last", i_last, want.last);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_model();
            awaited_msgs.delete();
        end else begin
            if (i_out_valid && !i_out_stall) check_result();
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                write_cfg(i_paddr[ADDR_W-1:2], i_pwdata);
            end
            if (i_in_valid && !i_in_stall) predict_item(i_opcode, i_rx_byte);
        end
        o_pending    <= awaited_msgs.size();
        o_fail_count <= mismatch_cnt;
    end

endmodule

// ----- tb/password_door_lock_controller_core_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// password_door_lock_controller_core_test
// Drives link bytes and timer ticks into the door lock controller: a short
// directed opening, then phases of random enroll, verify, tick and noise
// traffic under several register settings, with random idle cycles on the
// item side and random stalls on the result side. A separate checker
// predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module password_door_lock_controller_core_test;
    import dlc_pkg::*;

    localparam int unsigned PASS_LEN = 5;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 6;
    localparam int NUM_PHASES    = 8;

    typedef logic [PASS_LEN-1:0][7:0] t_code;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              opcode    = OP_BYTE;
    logic [7:0]        rx_byte   = 8'd0;
    logic              out_stall = 1'b0;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [ADDR_W-1:0] paddr     = '0;
    logic [31:0]       pwdata    = 32'd0;

    logic        in_stall;
    logic        out_valid;
    logic [3:0]  msg_code;
    logic [1:0]  motor_drive;
    logic        buzzer_on;
    logic        res_last;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int cycle_cnt;
    int items_sent = 0;
    int idle_pct   = 36;
    int stall_pct  = 36;
    int wrong_pct  = 30;
    int verify_pct = 50;

    // Local copy of the register settings, used to build command sequences.
    logic [7:0] cmd_check  = RST_CHECK_CMD;
    logic [7:0] cmd_ready  = RST_READY_CMD;
    logic [7:0] key_open   = RST_OPEN_KEY;
    logic [7:0] key_change = RST_CHANGE_KEY;
    logic [3:0] fail_limit = RST_MAX_FAILURES;
    logic [7:0] unlock_at  = RST_UNLOCK_TICKS;
    logic [7:0] relock_at  = RST_RELOCK_TICKS;
    logic [7:0] alarm_at   = RST_ALARM_TICKS;

    // Best guess of the saved code, and whether the block awaits a new one.
    t_code pw_guess    = '0;
    logic  want_enroll = 1'b0;

    password_door_lock_controller_core #(.PASS_LEN(PASS_LEN)) dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_opcode      (opcode),
        .i_rx_byte     (rx_byte),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_msg_code    (msg_code),
        .o_motor_drive (motor_drive),
        .o_buzzer_on   (buzzer_on),
        .o_last        (res_last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    dlc_result_check #(.PASS_LEN(PASS_LEN)) u_result_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_opcode      (opcode),
        .i_rx_byte     (rx_byte),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_msg_code    (msg_code),
        .i_motor_drive (motor_drive),
        .i_buzzer_on   (buzzer_on),
        .i_last        (res_last),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always #1 clk = ~clk;

    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Offers one item and returns at the edge of its transfer.
    task automatic put_item(input logic op, input logic [7:0] b);
        if ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        rx_byte  <= b;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    task automatic send_ticks(input int n);
        repeat (n) put_item(OP_TICK, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_code(input t_code code, input logic corrupt);
        int         bad_pos;
        logic [7:0] b;
        bad_pos = corrupt ? $urandom_range(0, PASS_LEN - 1) : -1;
        for (int k = 0; k < PASS_LEN; k++) begin
            b = code[k];
            if (k == bad_pos) b = b ^ (8'd1 << $urandom_range(0, 7));
            put_item(OP_BYTE, b);
        end
    endtask

    task automatic enroll_code(input t_code code, input logic bad_confirm);
        put_item(OP_BYTE, cmd_ready);
        send_code(code, 1'b0);
        put_item(OP_BYTE, cmd_ready);
        send_code(code, bad_confirm);
    endtask

    task automatic verify_code(input logic wrong, input logic [7:0] key);
        put_item(OP_BYTE, cmd_ready);
        send_code(pw_guess, wrong);
        put_item(OP_BYTE, key);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Waits until no result is awaited; the extra cycles cover items that end
    // without any message.
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial begin
        for (cycle_cnt = 0; cycle_cnt < CYCLE_LIMIT; cycle_cnt++) @(posedge clk);
        $display("Verification failed");
        $finish;
    end

    initial begin
        int         stop_at;
        int         pick;
        int         span;
        logic       bad;
        logic [7:0] key;
        t_code      fresh;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening with the reset settings.
        put_item(OP_BYTE, 8'hFF);            // not the check command, ignored
        put_item(OP_TICK, 8'h00);            // timer stopped, no message
        put_item(OP_BYTE, cmd_check);
        pw_guess = {8'hA5, cmd_ready, cmd_check, 8'hFF, 8'h00};
        enroll_code(pw_guess, 1'b0);
        verify_code(1'b0, key_open);
        send_ticks(relock_at);

        for (int p = 0; p < NUM_PHASES; p++) begin
            settle();
            idle_pct   = 36;
            stall_pct  = 36;
            wrong_pct  = 30;
            verify_pct = 50;
            cmd_check  = 8'($urandom_range(0, 255));
            cmd_ready  = 8'($urandom_range(0, 255));
            key_open   = 8'($urandom_range(0, 255));
            key_change = 8'($urandom_range(0, 255));
            fail_limit = 4'($urandom_range(1, 6));
            unlock_at  = 8'($urandom_range(1, 8));
            relock_at  = 8'($urandom_range(1, 12));
            alarm_at   = 8'($urandom_range(1, 16));
            case (p)
                1: begin
                    cmd_check  = 8'd0;
                    cmd_ready  = 8'd0;
                    key_open   = 8'd0;
                    key_change = 8'd0;
                    fail_limit = 4'd1;
                    unlock_at  = 8'd1;
                    relock_at  = 8'd1;
                    alarm_at   = 8'd1;
                end
                2: begin
                    cmd_check  = 8'hFF;
                    cmd_ready  = 8'hFF;
                    key_open   = 8'hFF;
                    key_change = 8'hFE;
                    fail_limit = 4'd15;
                    unlock_at  = 8'hFF;
                    relock_at  = 8'hFF;
                    alarm_at   = 8'hFF;
                end
                3: begin
                    key_change = key_open;
                    idle_pct   = 0;
                    stall_pct  = 0;
                end
                4: begin
                    // Long runs of wrong entries push the failure count to saturation.
                    fail_limit = 4'd2;
                    alarm_at   = 8'd200;
                    wrong_pct  = 95;
                    verify_pct = 95;
                end
                default: ;
            endcase
            write_reg(REG_CHECK_CMD, cmd_check);
            write_reg(REG_READY_CMD, cmd_ready);
            write_reg(REG_OPEN_KEY, key_open);
            write_reg(REG_CHANGE_KEY, key_change);
            write_reg(REG_MAX_FAILURES, {4'd0, fail_limit});
            write_reg(REG_UNLOCK_TICKS, unlock_at);
            write_reg(REG_RELOCK_TICKS, relock_at);
            write_reg(REG_ALARM_TICKS, alarm_at);

            span = unlock_at;
            if (relock_at > span) span = relock_at;
            if (alarm_at > span) span = alarm_at;

            stop_at = items_sent + ((p == 4) ? 160 : 40);
            while (items_sent < stop_at) begin
                if (want_enroll) begin
                    fresh = t_code'({$urandom, $urandom});
                    bad   = ($urandom_range(0, 99) < 25);
                    enroll_code(fresh, bad);
                    if (!bad) begin
                        pw_guess    = fresh;
                        want_enroll = 1'b0;
                    end
                end else if ($urandom_range(0, 99) < verify_pct) begin
                    bad  = ($urandom_range(0, 99) < wrong_pct);
                    pick = $urandom_range(0, 99);
                    if (pick < 45) key = key_open;
                    else if (pick < 65) key = key_change;
                    else key = 8'($urandom_range(0, 255));
                    verify_code(bad, key);
                    if (!bad && key == key_change) want_enroll = 1'b1;
                end else begin
                    pick = $urandom_range(0, 99);
                    if (pick < 50) begin
                        if ($urandom_range(0, 1)) send_ticks($urandom_range(1, 4));
                        else send_ticks($urandom_range(1, span + 1));
                    end else if (pick < 66) begin
                        // Out-of-turn enrollment: lands as a broken verify.
                        enroll_code(t_code'({$urandom, $urandom}),
                                    1'($urandom_range(0, 1)));
                    end else if (pick < 76) begin
                        put_item(OP_BYTE, cmd_check);
                    end else begin
                        repeat ($urandom_range(1, 3)) begin
                            put_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
                        end
                    end
                end
            end
        end

        settle();
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
